>>> hw/rtl/dgte_pkg.sv
`timescale 1ns / 1ps

package dgte_pkg;

    localparam int NUMBER_W      = 32;
    localparam int MAG_W         = 31;
    localparam int POS_W         = 24;
    localparam int DIGIT_COUNT_W = 5;
    localparam int GLYPH_W       = 4;
    localparam int COLS_W        = 5;
    localparam int WIDTH_W       = 16;
    localparam int SPACING_W     = 16;
    localparam int SCALE_W       = 12;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_TILE_COLUMNS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHAR_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GLYPH_SPACING = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DRAW_SCALE    = 2'd3;

    localparam logic [COLS_W-1:0]    TILE_COLUMNS_RST  = 5'd10;
    localparam logic [WIDTH_W-1:0]   CHAR_WIDTH_RST    = 16'd4096;
    localparam logic [SPACING_W-1:0] GLYPH_SPACING_RST = 16'd0;
    localparam logic [SCALE_W-1:0]   DRAW_SCALE_RST    = 12'd256;

    localparam logic [GLYPH_W-1:0] GLYPH_PLUS  = 4'd10;
    localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 4'd11;

    localparam logic [MAG_W-1:0] MAG_MAX      = 31'h7FFF_FFFF;
    localparam logic [MAG_W-1:0] DECIMAL_BASE = 31'd10;
    localparam logic [31:0]      RECIP_TEN    = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT  = 35;

    // tile columns beyond this value all place every glyph in row 0
    localparam logic [3:0] COLS_CLIP = 4'd12;

    typedef logic [2:0] step_t;

    localparam step_t STEP_IDLE  = 3'd0;
    localparam step_t STEP_MULT  = 3'd1;
    localparam step_t STEP_PLACE = 3'd2;
    localparam step_t STEP_DIGIT = 3'd3;
    localparam step_t STEP_SIGN  = 3'd4;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_START,
        COND_MORE
    } cond_t;

    typedef struct packed {
        logic load;
        logic mult;
        logic place;
        logic digit;
        logic sign;
    } ctrl_t;

    typedef struct packed {
        logic start;
        logic more;
    } flags_t;

    typedef struct packed {
        ctrl_t ctrl;
        cond_t cond;
        step_t target;
    } uword_t;

    function automatic uword_t ucode(input step_t pc);
        uword_t w;
        w = '{ctrl: '0, cond: COND_NEVER, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE:
            begin
                w.ctrl.load = 1'b1;
                w.cond      = COND_NO_START;
                w.target    = STEP_IDLE;
            end
            STEP_MULT:
            begin
                w.ctrl.mult = 1'b1;
            end
            STEP_PLACE:
            begin
                w.ctrl.place = 1'b1;
            end
            STEP_DIGIT:
            begin
                w.ctrl.digit = 1'b1;
                w.cond       = COND_MORE;
                w.target     = STEP_DIGIT;
            end
            STEP_SIGN:
            begin
                w.ctrl.sign = 1'b1;
                w.cond      = COND_ALWAYS;
                w.target    = STEP_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // entry {glyph, columns} holds {row, col}
    typedef logic [7:0] tile_lut_t [256];

    function automatic tile_lut_t build_tile_lut();
        tile_lut_t lut;
        int v;
        int r;
        int cc;
        for (int g = 0; g < 16; g++)
        begin
            for (int c = 0; c < 16; c++)
            begin
                cc = (c == 0) ? 1 : c;
                v  = g;
                r  = 0;
                for (int s = 0; s < 16; s++)
                begin
                    if (v >= cc)
                    begin
                        v = v - cc;
                        r = r + 1;
                    end
                end
                lut[g * 16 + c] = {4'(r), 4'(v)};
            end
        end
        return lut;
    endfunction

    localparam tile_lut_t TILE_LUT = build_tile_lut();

endpackage

>>> hw/rtl/dgte_seq.sv
`timescale 1ns / 1ps

module dgte_seq import dgte_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl,
    output logic   busy
);

    step_t  pc_reg;
    step_t  pc_next;
    uword_t uw;
    logic   jump;

    assign uw   = ucode(pc_reg);
    assign ctrl = uw.ctrl;
    assign busy = (pc_reg != STEP_IDLE);

    always_comb
    begin
        unique case (uw.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_START: jump = !flags.start;
            COND_MORE:     jump = flags.more;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? uw.target : step_t'(pc_reg + 3'd1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hw/rtl/decimal_glyph_tile_emitter.sv
`timescale 1ns / 1ps
// channel   signals                                              transfer when
// ------    ---------------------------------------------------  ------------------
// input     number origin_x origin_y digit_count show_plus       start && !busy
// result    pos_x pos_y glyph_index tile_col tile_row last_glyph result_strobe
// config    cfg_index cfg_data                                   cfg_we
//
// a number passes accept, offset multiply, placement, one digit per cycle through a
// shared reciprocal multiplier, then the sign step
// the next start is taken in the cycle the sign glyph is out, or in the cycle after the
// last digit when no sign glyph is shown
// results last one cycle each, no stall; rst_n clears sequencer, strobe and config registers

module decimal_glyph_tile_emitter import dgte_pkg::*;
#(
    parameter int MAX_DIGITS = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [NUMBER_W-1:0]    number,
    input  logic signed [POS_W-1:0]       origin_x,
    input  logic signed [POS_W-1:0]       origin_y,
    input  logic [DIGIT_COUNT_W-1:0]      digit_count,
    input  logic                          show_plus,
    output logic                          result_strobe,
    output logic signed [POS_W-1:0]       pos_x,
    output logic signed [POS_W-1:0]       pos_y,
    output logic [GLYPH_W-1:0]            glyph_index,
    output logic [3:0]                    tile_col,
    output logic [3:0]                    tile_row,
    output logic                          last_glyph,
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    localparam int CNT_W = ($clog2(MAX_DIGITS + 1) > DIGIT_COUNT_W) ?
                           $clog2(MAX_DIGITS + 1) : DIGIT_COUNT_W;

    ctrl_t  ctrl;
    flags_t flags;
    logic   accept;

    logic [COLS_W-1:0]           tile_columns_reg;
    logic [WIDTH_W-1:0]          char_width_reg;
    logic signed [SPACING_W-1:0] glyph_spacing_reg;
    logic [SCALE_W-1:0]          draw_scale_reg;

    logic [MAG_W-1:0]        mag_reg;
    logic [MAG_W-1:0]        quot_reg;
    logic [POS_W-1:0]        ax_reg;
    logic [POS_W-1:0]        ay_reg;
    logic [CNT_W-1:0]        dc_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic [GLYPH_W-1:0]      sign_glyph_reg;
    logic                    has_sign_reg;
    logic [27:0]             prod_off_reg;
    logic signed [29:0]      prod_step_reg;
    logic [POS_W-1:0]        x_reg;
    logic [POS_W-1:0]        step_reg;

    logic                    strobe_reg;
    logic [POS_W-1:0]        pos_x_reg;
    logic [POS_W-1:0]        pos_y_reg;
    logic [GLYPH_W-1:0]      glyph_reg;
    logic [3:0]              tile_col_reg;
    logic [3:0]              tile_row_reg;
    logic                    last_reg;

    logic                    neg;
    logic [NUMBER_W-1:0]     mag_abs;
    logic [MAG_W-1:0]        mag_next;
    logic [CNT_W-1:0]        dc_ext;
    logic [CNT_W-1:0]        dc_next;

    logic signed [17:0]      width_sum;
    logic [27:0]             prod_off_next;
    logic signed [29:0]      prod_step_next;
    logic [28:0]             off_round;
    logic signed [30:0]      step_round;

    logic [MAG_W-1:0]        qmul_in;
    logic [62:0]             qprod;
    logic [MAG_W-1:0]        quot_next;
    logic [MAG_W-1:0]        ten_q;
    logic [GLYPH_W-1:0]      digit_val;
    logic                    fixed_len;
    logic                    more;

    logic [3:0]              cols_clip;
    logic [GLYPH_W-1:0]      glyph_sel;
    logic [7:0]              tile_entry;

    dgte_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl),
        .busy  (busy)
    );

    assign accept = ctrl.load && start;
    assign flags  = '{start: start, more: more};

    // input conditioning
    assign neg      = number[NUMBER_W-1];
    assign mag_abs  = neg ? (~number + 32'd1) : number;
    assign mag_next = mag_abs[NUMBER_W-1] ? MAG_MAX : mag_abs[MAG_W-1:0];
    assign dc_ext   = CNT_W'(digit_count);
    assign dc_next  = (dc_ext > CNT_W'(MAX_DIGITS)) ? CNT_W'(MAX_DIGITS) : dc_ext;

    // offset and step products
    assign width_sum      = 18'(glyph_spacing_reg) + $signed({2'b00, char_width_reg});
    assign prod_off_next  = 28'(draw_scale_reg) * 28'(char_width_reg);
    assign prod_step_next = 30'($signed({1'b0, draw_scale_reg})) * 30'(width_sum);
    assign off_round      = {1'b0, prod_off_reg} + 29'd128;
    assign step_round     = 31'(prod_step_reg) + 31'sd128;

    // divide by ten through the reciprocal
    assign qmul_in   = ctrl.mult ? mag_reg : quot_reg;
    assign qprod     = {32'b0, qmul_in} * {31'b0, RECIP_TEN};
    assign quot_next = MAG_W'(qprod >> RECIP_SHIFT);
    assign ten_q     = (quot_reg << 3) + (quot_reg << 1);
    assign digit_val = GLYPH_W'(mag_reg - ten_q);

    assign fixed_len = (dc_reg != '0);
    assign more      = fixed_len ? (CNT_W'(cnt_reg + CNT_W'(1)) != dc_reg)
                                 : (mag_reg >= DECIMAL_BASE);

    // tile sheet placement
    assign cols_clip  = (tile_columns_reg == '0) ? 4'd1 :
                        (tile_columns_reg > COLS_W'(COLS_CLIP)) ? COLS_CLIP :
                        tile_columns_reg[3:0];
    assign glyph_sel  = ctrl.sign ? sign_glyph_reg : digit_val;
    assign tile_entry = TILE_LUT[{glyph_sel, cols_clip}];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_columns_reg  <= TILE_COLUMNS_RST;
            char_width_reg    <= CHAR_WIDTH_RST;
            glyph_spacing_reg <= GLYPH_SPACING_RST;
            draw_scale_reg    <= DRAW_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TILE_COLUMNS:  tile_columns_reg  <= cfg_data[COLS_W-1:0];
                REG_CHAR_WIDTH:    char_width_reg    <= cfg_data[WIDTH_W-1:0];
                REG_GLYPH_SPACING: glyph_spacing_reg <= cfg_data[SPACING_W-1:0];
                REG_DRAW_SCALE:    draw_scale_reg    <= cfg_data[SCALE_W-1:0];
                default:           tile_columns_reg  <= tile_columns_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctrl.digit || (ctrl.sign && has_sign_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg        <= mag_next;
            ax_reg         <= origin_x;
            ay_reg         <= origin_y;
            dc_reg         <= dc_next;
            cnt_reg        <= '0;
            sign_glyph_reg <= neg ? GLYPH_MINUS : GLYPH_PLUS;
            has_sign_reg   <= neg || show_plus;
        end
        if (ctrl.mult)
        begin
            prod_off_reg  <= prod_off_next;
            prod_step_reg <= prod_step_next;
            quot_reg      <= quot_next;
        end
        if (ctrl.place)
        begin
            x_reg    <= ax_reg - POS_W'(off_round[28:8]);
            step_reg <= {step_round[30], step_round[30:8]};
        end
        if (ctrl.digit)
        begin
            mag_reg  <= quot_reg;
            quot_reg <= quot_next;
            cnt_reg  <= CNT_W'(cnt_reg + CNT_W'(1));
            x_reg    <= x_reg - step_reg;
        end
        if (ctrl.digit || ctrl.sign)
        begin
            pos_x_reg    <= x_reg;
            pos_y_reg    <= ay_reg;
            glyph_reg    <= glyph_sel;
            tile_row_reg <= tile_entry[7:4];
            tile_col_reg <= tile_entry[3:0];
            last_reg     <= ctrl.sign || (!more && !has_sign_reg);
        end
    end

    assign result_strobe = strobe_reg;
    assign pos_x         = pos_x_reg;
    assign pos_y         = pos_y_reg;
    assign glyph_index   = glyph_reg;
    assign tile_col      = tile_col_reg;
    assign tile_row      = tile_row_reg;
    assign last_glyph    = last_reg;

endmodule

>>> hw/rtl/dgte_checker.sv
`timescale 1ns / 1ps

module dgte_checker import dgte_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_strobe,
    input logic [GLYPH_W-1:0] glyph_index,
    input logic               last_glyph
);

    // a taken number keeps the block busy
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after a start transfer");

    // no glyph comes out during the set-up of a new number
    a_setup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> !result_strobe ##1 !result_strobe)
        else $error("result during set-up of a number");

    a_glyph_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe |-> (glyph_index <= GLYPH_MINUS))
        else $error("glyph index out of range");

    // a sign glyph always closes the number
    a_sign_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && (glyph_index == GLYPH_PLUS || glyph_index == GLYPH_MINUS))
        |-> last_glyph)
        else $error("sign glyph not marked last");

    // glyphs of one number come in consecutive cycles
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_glyph) |=> result_strobe)
        else $error("gap inside the glyphs of one number");

endmodule

bind decimal_glyph_tile_emitter dgte_checker u_dgte_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .glyph_index   (glyph_index),
    .last_glyph    (last_glyph)
);
